### design/cssd_pkg.sv
// ----------------------------------------------------------------------------
// Clock seven-segment scan driver package
// Item types, display constants and the digit-to-segment decoder shared by
// the scan driver.
// ----------------------------------------------------------------------------
package cssd_pkg;

  localparam int unsigned MinuteW = 11;
  localparam int unsigned PosW    = 2;
  localparam int unsigned SegW    = 8;
  localparam int unsigned DigitsN = 4;

  localparam logic [MinuteW-1:0] LastMinute   = 11'd1439;
  localparam logic [SegW-1:0]    BlankPattern = 8'hFF;
  localparam logic [DigitsN-1:0] AllDigitsOff = 4'hF;

  // Digit positions on the display.
  localparam logic [PosW-1:0] PosMinUnits  = 2'd0;
  localparam logic [PosW-1:0] PosMinTens   = 2'd1;
  localparam logic [PosW-1:0] PosHourUnits = 2'd2;
  localparam logic [PosW-1:0] PosHourTens  = 2'd3;

  typedef struct packed {
    logic [MinuteW-1:0] minutes_of_day;
    logic [PosW-1:0]    digit_position;
    logic               setting_active;
    logic [PosW-1:0]    cursor_digit;
    logic               blink_on;
  } in_item_t;

  typedef struct packed {
    logic [SegW-1:0]    segment_pattern;
    logic [DigitsN-1:0] digit_enable;
  } out_item_t;

  // Active-low segments a..g in bits 0..6, decimal point off in bit 7.
  function automatic logic [SegW-1:0] seg_of_digit(input logic [3:0] digit);
    logic [SegW-1:0] seg;
    case (digit)
      4'd0:    seg = 8'b11000000;
      4'd1:    seg = 8'b11111001;
      4'd2:    seg = 8'b10100100;
      4'd3:    seg = 8'b10110000;
      4'd4:    seg = 8'b10011001;
      4'd5:    seg = 8'b10010010;
      4'd6:    seg = 8'b10000010;
      4'd7:    seg = 8'b11111000;
      4'd8:    seg = 8'b10000000;
      4'd9:    seg = 8'b10010000;
      default: seg = BlankPattern;
    endcase
    return seg;
  endfunction

endpackage

### design/clock_seven_segment_scan_driver_unit.sv
// ----------------------------------------------------------------------------
// Clock seven-segment scan driver
// Turns one scan step of a four-digit clock display into the segment
// pattern and digit enable for the addressed position.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake               Payload
//  --------  ---------  ----------------------  -------------------------------
//  in        input      in_valid_i/in_ready_o   in_item_i  (cssd_pkg::in_item_t)
//  out       output     out_valid_o/out_ready_i out_item_o (cssd_pkg::out_item_t)
//  cfg       input      cfg_we_i                cfg_wdata_i (twelve_hour_mode)
//
// Each item passes through the input register and then the result
// register, from which its result is offered on the output channel.
// A new item can be accepted in every cycle unless an output stall has
// filled both registers; the two registers form a two-entry pipeline
// whose ready signals chain backward from out_ready_i.
// A stall on the output holds the result register, and the input register
// holds too once it is full, after which in_ready_o drops.
// Reset clears both valid flags and returns the display to 24-hour mode.
//
module clock_seven_segment_scan_driver_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cssd_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cssd_pkg::out_item_t  out_item_o
);
  import cssd_pkg::*;

  // Configuration register.
  logic mode12_q;

  // Input stage.
  logic     s1_valid_q;
  in_item_t s1_item_q;
  logic     s1_ready;

  // Result stage.
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t out_item_d;

  // Arithmetic between the two stages.
  logic [MinuteW-1:0] count;
  logic [21:0]        hour_prod;
  logic [4:0]         hour;
  logic [MinuteW-1:0] hour_x60;
  logic [5:0]         minute;
  logic [4:0]         shown;
  logic [10:0]        min_prod;
  logic [2:0]         min_tens;
  logic [3:0]         min_units;
  logic [1:0]         hr_tens;
  logic [3:0]         hr_units;
  logic [3:0]         digit;
  logic               blank;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode12_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode12_q <= cfg_wdata_i;
    end
  end

  // The result register frees up when it is empty or its item is taken,
  // and the input register when its item can move on.
  assign s1_ready   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_item_q <= in_item_i;
    end
  end

  always_comb begin
    // Counts past the end of the day show as the last minute.
    count = (s1_item_q.minutes_of_day > LastMinute) ? LastMinute
                                                    : s1_item_q.minutes_of_day;

    // Divide by 60 as a multiply by 1093/65536, exact for counts up to 1439.
    hour_prod = 22'(count) * 22'd1093;
    hour      = hour_prod[20:16];
    hour_x60  = (MinuteW'(hour) << 6) - (MinuteW'(hour) << 2);
    minute    = 6'(count - hour_x60);

    // In 12-hour form both midnight and noon show as 12.
    if (!mode12_q) begin
      shown = hour;
    end else if (hour == 5'd0) begin
      shown = 5'd12;
    end else if (hour > 5'd12) begin
      shown = hour - 5'd12;
    end else begin
      shown = hour;
    end

    // Minute tens as a multiply by 13/128, exact below 69.
    min_prod  = 11'(minute) * 11'd13;
    min_tens  = min_prod[9:7];
    min_units = 4'(minute - 6'(min_tens) * 6'd10);

    // Hours never exceed 23, so two compares give the tens digit.
    if (shown >= 5'd20) begin
      hr_tens = 2'd2;
    end else if (shown >= 5'd10) begin
      hr_tens = 2'd1;
    end else begin
      hr_tens = 2'd0;
    end
    hr_units = 4'(shown - 5'(hr_tens) * 5'd10);

    case (s1_item_q.digit_position)
      PosMinUnits:  digit = min_units;
      PosMinTens:   digit = 4'(min_tens);
      PosHourUnits: digit = hr_units;
      PosHourTens:  digit = 4'(hr_tens);
      default:      digit = min_units;
    endcase

    // While setting is active, the digit under the cursor goes dark in the off blink phase.
    blank = s1_item_q.setting_active && !s1_item_q.blink_on &&
            (s1_item_q.cursor_digit == s1_item_q.digit_position);

    out_item_d.segment_pattern = blank ? BlankPattern : seg_of_digit(digit);
    out_item_d.digit_enable    = AllDigitsOff ^
                                 (DigitsN'(1) << s1_item_q.digit_position);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_ready) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // An accepted item always lands in the input register.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> s1_valid_q)
    else $error("accepted item did not reach the input register");

  // An item that leaves the input register always lands in the result register.
  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_ready |=> out_valid_q)
    else $error("item lost between input and result registers");

  // Exactly one digit is enabled on every result.
  a_one_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $countones(~out_item_q.digit_enable) == 1)
    else $error("digit enable is not one-hot active-low");

  // The decimal point stays off.
  a_dp_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_item_q.segment_pattern[SegW-1])
    else $error("decimal point driven");

endmodule
